// File: sv/ipv4_transport_header_parser_core_assert.svh
// assertion macros for the ipv4 transport header parser checker
// expects clk and rst in the scope of each use
`ifndef IPV4_TRANSPORT_HEADER_PARSER_CORE_ASSERT_SVH
`define IPV4_TRANSPORT_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define IPHP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iphp check failed");

// next-cycle implication, off during reset
`define IPHP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iphp check failed");

// next-cycle implication, also checked during reset
`define IPHP_ASSERT_RST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("iphp reset check failed");

`endif

// File: sv/iphp_pkg.sv
// shared types and constants of the ipv4 transport header parser
// no dependencies
package iphp_pkg;

  localparam int IPHP_QUEUE_DEPTH = 2;

  localparam logic [15:0] IP_POS_VER_IHL = 16'd0;
  localparam logic [15:0] IP_POS_TOTLEN  = 16'd2;
  localparam logic [15:0] IP_POS_PROTO   = 16'd9;
  localparam logic [15:0] IP_POS_SRC     = 16'd12;
  localparam logic [15:0] IP_POS_DST     = 16'd16;
  localparam logic [15:0] IP_MIN_BYTES   = 16'd20;
  localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  // captured header state, also the record handed from front to back
  typedef struct packed {
    logic [15:0] byte_count;
    logic [3:0]  ihl;
    logic [7:0]  protocol;
    logic [15:0] total_length;
    logic [31:0] source;
    logic [31:0] destination;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [63:0] seq_ack;
    logic [15:0] offset_flags;
    logic [15:0] window_len;
  } capture_t;

  // result record, status in the lowest bits
  typedef struct packed {
    logic [15:0] payload_length;
    logic [6:0]  payload_offset;
    logic [15:0] window_or_udp_length;
    logic [15:0] offset_and_flags;
    logic [63:0] seq_and_ack;
    logic [15:0] destination_port;
    logic [15:0] source_port;
    logic [31:0] destination_address;
    logic [31:0] source_address;
    logic [15:0] total_length;
    logic [7:0]  protocol;
    status_t     status;
  } result_t;

  localparam int IPHP_RESULT_W = $bits(result_t);
  localparam int IPHP_TDATA_W  = ((IPHP_RESULT_W + 7) / 8) * 8;
  localparam int IPHP_STATUS_W = 2;
  localparam int IPHP_SPORT_LSB = IPHP_STATUS_W + 8 + 16 + 32 + 32;

endpackage

// File: sv/ipv4_transport_header_parser_core.sv
// channel  dir  signals                          carries
// s_axis   in   tvalid tready tdata[7:0] tlast   packet bytes, tlast on last byte
// m_axis   out  tvalid tready tdata[247:0]       one header record per packet
//
// one byte accepted per cycle while s_axis_tready is high; m_axis_tvalid rises
// once the record of the last byte has passed the record queue and the back output register
// reset is synchronous and clears the byte position, captured fields, queue
// and output valid
// s_axis_tready drops only while the record queue is full, which happens
// when m_axis stalls with a record waiting and further records arrive
// top level of the ipv4 transport header parser, depends on iphp_pkg,
// iphp_front, iphp_queue and iphp_back
module ipv4_transport_header_parser_core
  import iphp_pkg::*;
#(
  parameter int QUEUE_DEPTH = IPHP_QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // data_byte
  input  logic                    s_axis_tlast,   // end_of_buffer
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // status, protocol, total_length, source_address, destination_address,
  // source_port, destination_port, seq_and_ack, offset_and_flags,
  // window_or_udp_length, payload_offset, payload_length, zero fill
  output logic [IPHP_TDATA_W-1:0] m_axis_tdata
);

  logic     push_valid;
  logic     push_ready;
  capture_t push_rec;
  logic     pop_valid;
  logic     pop_ready;
  capture_t pop_rec;
  result_t  res;

  iphp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  iphp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  iphp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pop_valid),
    .in_ready  (pop_ready),
    .in_rec    (pop_rec),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  assign m_axis_tdata = {{(IPHP_TDATA_W - IPHP_RESULT_W){1'b0}}, res};

endmodule

// File: sv/iphp_front.sv
// front part: byte position tracking and header field capture
// depends on iphp_pkg
module iphp_front
  import iphp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       push_valid,
  input  logic       push_ready,
  output capture_t   push_rec
);

  capture_t    cap;
  capture_t    cap_next;
  logic [15:0] pos;
  logic [3:0]  ihl_cur;
  logic [15:0] hoff;
  logic [15:0] tofs;
  logic [3:0]  tpos;
  logic [2:0]  seq_lane;
  logic [1:0]  addr_lane;
  logic        accept;

  assign pos      = cap.byte_count;
  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign ihl_cur  = (pos == IP_POS_VER_IHL) ? in_byte[3:0] : cap.ihl;
  assign hoff     = {10'd0, ihl_cur, 2'b00};
  assign tofs     = pos - hoff;
  assign tpos     = tofs[3:0];
  assign seq_lane = 3'(4'd11 - tpos);
  assign addr_lane = 2'd3 - pos[1:0];

  always_comb begin
    cap_next = cap;
    if (pos != COUNT_MAX) begin
      cap_next.byte_count = pos + 16'd1;
    end
    if (pos == IP_POS_VER_IHL) begin
      cap_next.ihl = in_byte[3:0];
    end else if (pos == IP_POS_TOTLEN) begin
      cap_next.total_length[15:8] = in_byte;
    end else if (pos == IP_POS_TOTLEN + 16'd1) begin
      cap_next.total_length[7:0] = in_byte;
    end else if (pos == IP_POS_PROTO) begin
      cap_next.protocol = in_byte;
    end else if (pos >= IP_POS_SRC && pos < IP_POS_DST) begin
      cap_next.source[{addr_lane, 3'b000} +: 8] = in_byte;
    end else if (pos >= IP_POS_DST && pos < IP_MIN_BYTES) begin
      cap_next.destination[{addr_lane, 3'b000} +: 8] = in_byte;
    end
    if (pos >= hoff && tofs[15:4] == 12'd0) begin
      unique case (tpos)
        4'd0:  cap_next.source_port[15:8]      = in_byte;
        4'd1:  cap_next.source_port[7:0]       = in_byte;
        4'd2:  cap_next.destination_port[15:8] = in_byte;
        4'd3:  cap_next.destination_port[7:0]  = in_byte;
        4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11:
          cap_next.seq_ack[{seq_lane, 3'b000} +: 8] = in_byte;
        4'd12: cap_next.offset_flags[15:8]     = in_byte;
        4'd13: cap_next.offset_flags[7:0]      = in_byte;
        4'd14: cap_next.window_len[15:8]       = in_byte;
        4'd15: cap_next.window_len[7:0]        = in_byte;
      endcase
    end
  end

  assign push_valid = accept && in_last;
  assign push_rec   = cap_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= '0;
    end else if (accept) begin
      if (in_last) begin
        cap <= '0;
      end else begin
        cap <= cap_next;
      end
    end
  end

endmodule

// File: sv/iphp_queue.sv
// short record queue between the capture front and the result back
// depends on iphp_pkg
module iphp_queue
  import iphp_pkg::*;
#(
  parameter int DEPTH = IPHP_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  capture_t push_rec,
  output logic     pop_valid,
  input  logic     pop_ready,
  output capture_t pop_rec
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  capture_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_rec    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/iphp_back.sv
// back part: status, payload offset and length, output register
// depends on iphp_pkg
module iphp_back
  import iphp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  capture_t in_rec,
  output logic     out_valid,
  input  logic     out_ready,
  output result_t  out_res
);

  result_t     res;
  logic [6:0]  hb;
  logic [6:0]  tcp_off;
  logic [15:0] udp_len;

  function automatic logic [15:0] sat_sub(input logic [15:0] a, input logic [15:0] b);
    sat_sub = (a > b) ? a - b : 16'd0;
  endfunction

  assign hb      = {1'b0, in_rec.ihl, 2'b00};
  assign tcp_off = hb + {1'b0, in_rec.offset_flags[15:12], 2'b00};
  assign udp_len = in_rec.seq_ack[63:48];

  always_comb begin
    res = '0;
    if (in_rec.byte_count < IP_MIN_BYTES) begin
      res.status = ST_SHORT;
    end else begin
      res.protocol            = in_rec.protocol;
      res.total_length        = in_rec.total_length;
      res.source_address      = in_rec.source;
      res.destination_address = in_rec.destination;
      if (in_rec.byte_count < in_rec.total_length) begin
        res.status = ST_TRUNC;
      end else begin
        res.status = ST_OK;
        unique case (in_rec.protocol)
          PROTO_TCP: begin
            res.source_port          = in_rec.source_port;
            res.destination_port     = in_rec.destination_port;
            res.seq_and_ack          = in_rec.seq_ack;
            res.offset_and_flags     = in_rec.offset_flags;
            res.window_or_udp_length = in_rec.window_len;
            res.payload_offset       = tcp_off;
            res.payload_length       = sat_sub(in_rec.total_length, {9'd0, tcp_off});
          end
          PROTO_UDP: begin
            res.source_port          = in_rec.source_port;
            res.destination_port     = in_rec.destination_port;
            res.window_or_udp_length = udp_len;
            res.payload_offset       = hb + UDP_HDR_BYTES[6:0];
            res.payload_length       = sat_sub(udp_len, UDP_HDR_BYTES);
          end
          default: begin
            res.payload_offset = hb;
            res.payload_length = sat_sub(in_rec.total_length, {9'd0, hb});
          end
        endcase
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: sv/iphp_checker.sv
// port-level checks of the ipv4 transport header parser, bound to the top
// depends on iphp_pkg and ipv4_transport_header_parser_core_assert.svh
`include "ipv4_transport_header_parser_core_assert.svh"

module iphp_checker
  import iphp_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    s_axis_tvalid,
  input logic                    s_axis_tready,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [IPHP_TDATA_W-1:0] m_axis_tdata
);

  logic is_short;
  logic is_trunc;

  assign is_short = m_axis_tdata[IPHP_STATUS_W-1:0] == ST_SHORT;
  assign is_trunc = m_axis_tdata[IPHP_STATUS_W-1:0] == ST_TRUNC;

  `IPHP_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `IPHP_ASSERT_IMP(a_short_zero, m_axis_tvalid && is_short, m_axis_tdata[IPHP_TDATA_W-1:IPHP_STATUS_W] == '0)
  `IPHP_ASSERT_IMP(a_trunc_zero, m_axis_tvalid && is_trunc, m_axis_tdata[IPHP_TDATA_W-1:IPHP_SPORT_LSB] == '0)
  `IPHP_ASSERT_IMP(a_stall_cause, !s_axis_tready, m_axis_tvalid)
  `IPHP_ASSERT_RST_NXT(a_reset_idle, rst, !m_axis_tvalid)

endmodule

bind ipv4_transport_header_parser_core iphp_checker u_iphp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
